// ===== rtl/twm_pkg.sv =====
// Shared types and constants for the three-voice wavetable mixer.
`timescale 1ns / 1ps
package twm_pkg;

	localparam int VOICE_COUNT = 3;
	localparam int PHASE_W     = 16;
	localparam int TBL_IDX_W   = 8;
	localparam int SAMPLE_W    = 8;
	localparam int REG_IDX_W   = 2;
	localparam int SUM_W       = 10;
	localparam int MIX_W       = 10;

	typedef logic [PHASE_W-1:0]   phase_t;
	typedef logic [TBL_IDX_W-1:0] tbl_idx_t;
	typedef logic [SAMPLE_W-1:0]  sample_t;

	typedef tbl_idx_t [VOICE_COUNT-1:0] voice_idx_t;
	typedef sample_t  [VOICE_COUNT-1:0] voice_data_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_STEP_A = 2'd0,
		REG_STEP_B = 2'd1,
		REG_STEP_C = 2'd2
	} cfg_reg_t;

	// Mix offset, upper clamp and output bias
	localparam logic signed [MIX_W-1:0] MIX_OFFSET = 10'sd127;
	localparam logic signed [MIX_W-1:0] MIX_MAX    = 10'sd127;
	localparam logic signed [MIX_W-1:0] OUT_BIAS   = 10'sd128;

	// Pipeline status from the mixer stage
	typedef struct packed {
		logic s1_valid;
		logic in_ready;
	} pipe_stat_t;

endpackage

// ===== rtl/twm_item_if.sv =====
// Input item channel: table write or sample tick.
`timescale 1ns / 1ps
interface twm_item_if;
	import twm_pkg::*;

	logic     valid;
	logic     ready;
	logic     op;
	tbl_idx_t table_index;
	sample_t  table_value;

	modport source (output valid, op, table_index, table_value, input ready);
	modport sink   (input valid, op, table_index, table_value, output ready);
endinterface

// ===== rtl/twm_sample_if.sv =====
// Output sample channel.
`timescale 1ns / 1ps
interface twm_sample_if;
	import twm_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_out;

	modport source (output valid, sample_out, input ready);
	modport sink   (input valid, sample_out, output ready);
endinterface

// ===== rtl/twm_cfg_if.sv =====
// Configuration write channel.
`timescale 1ns / 1ps
interface twm_cfg_if;
	import twm_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] reg_index;
	phase_t               wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== rtl/three_voice_wavetable_mixer_top.sv =====
// A tick's sample passes through the table read stage and then the output register before it is offered.
// Throughput: one item per cycle; the table read stage and the output register
// decouple input and output, so input stalls only when both are full.
// Table writes take effect at once and produce no sample.
// Reset: async active low; step and phase registers clear, table valid bits clear
// so every entry reads zero, no clearing sweep is needed.
`timescale 1ns / 1ps
module three_voice_wavetable_mixer_top
	import twm_pkg::*;
#(
	parameter int TABLE_DEPTH = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	twm_item_if.sink     item,
	twm_sample_if.source sample,
	twm_cfg_if.sink      cfg
);

	logic        item_acc;
	logic        tick_acc;
	logic        wr_acc;
	voice_idx_t  rd_idx;
	voice_data_t rd_data_s1;
	pipe_stat_t  pipe;

	assign item.ready = pipe.in_ready;
	assign item_acc   = item.valid && item.ready;
	assign tick_acc   = item_acc && (item.op == OP_TICK);
	assign wr_acc     = item_acc && (item.op == OP_WRITE);

	twm_voice_core u_voice (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.tick_acc (tick_acc),
		.rd_idx   (rd_idx)
	);

	twm_wave_mem #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_acc),
		.wr_idx     (item.table_index),
		.wr_data    (item.table_value),
		.rd_en      (tick_acc),
		.rd_idx     (rd_idx),
		.rd_data_s1 (rd_data_s1)
	);

	twm_mix u_mix (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_acc   (tick_acc),
		.rd_data_s1 (rd_data_s1),
		.stat       (pipe),
		.sample     (sample)
	);

`ifndef SYNTHESIS
	a_out_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sample.valid) |-> $past(pipe.s1_valid))
		else $error("sample raised without a tick in the read stage");

	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_acc |=> $stable(rd_idx))
		else $error("phase moved without a tick");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pipe.s1_valid && sample.valid && !sample.ready) |=> pipe.s1_valid)
		else $error("read stage dropped a tick under backpressure");
`endif

endmodule

// ===== rtl/twm_wave_mem.sv =====
// Waveform table: two mirrored RAM copies, valid bits cleared at reset, three read ports.
`timescale 1ns / 1ps
module twm_wave_mem
	import twm_pkg::*;
#(
	parameter int TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  tbl_idx_t    wr_idx,
	input  sample_t     wr_data,
	input  logic        rd_en,
	input  voice_idx_t  rd_idx,
	output voice_data_t rd_data_s1
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [TBL_IDX_W:0] DEPTH_L = (TBL_IDX_W+1)'(TABLE_DEPTH);

	// Copy A serves voices one and two, copy B serves voice three
	sample_t mem_a [TABLE_DEPTH];
	sample_t mem_b [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;

	logic                       wr_hit;
	logic [VOICE_COUNT-1:0]     rd_hit;
	logic [VOICE_COUNT-1:0][AW-1:0] rd_addr;
	logic [AW-1:0]              wr_addr;

	assign wr_addr = wr_idx[AW-1:0];
	assign wr_hit  = wr_en && ({1'b0, wr_idx} < DEPTH_L);

	always_comb begin
		for (int v = 0; v < VOICE_COUNT; v++) begin
			rd_addr[v] = rd_idx[v][AW-1:0];
			rd_hit[v]  = ({1'b0, rd_idx[v]} < DEPTH_L) && valid_q[rd_addr[v]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_hit) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			mem_a[wr_addr] <= wr_data;
			mem_b[wr_addr] <= wr_data;
		end
	end

	// Entries never written, or beyond the table, read as zero
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1[0] <= rd_hit[0] ? mem_a[rd_addr[0]] : '0;
			rd_data_s1[1] <= rd_hit[1] ? mem_a[rd_addr[1]] : '0;
			rd_data_s1[2] <= rd_hit[2] ? mem_b[rd_addr[2]] : '0;
		end
	end

endmodule

// ===== rtl/twm_voice_core.sv =====
// Per-voice step registers and phase accumulators.
`timescale 1ns / 1ps
module twm_voice_core
	import twm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	twm_cfg_if.sink    cfg,
	input  logic       tick_acc,
	output voice_idx_t rd_idx
);

	phase_t step_q  [VOICE_COUNT];
	phase_t phase_q [VOICE_COUNT];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VOICE_COUNT; v++) step_q[v] <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				REG_STEP_A: step_q[0] <= cfg.wr_data;
				REG_STEP_B: step_q[1] <= cfg.wr_data;
				REG_STEP_C: step_q[2] <= cfg.wr_data;
				default: ;
			endcase
		end
	end

	// Table is addressed by the integer part of the phase before it advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VOICE_COUNT; v++) phase_q[v] <= '0;
		end else if (tick_acc) begin
			for (int v = 0; v < VOICE_COUNT; v++) phase_q[v] <= phase_q[v] + step_q[v];
		end
	end

	always_comb begin
		for (int v = 0; v < VOICE_COUNT; v++) rd_idx[v] = phase_q[v][PHASE_W-1 -: TBL_IDX_W];
	end

endmodule

// ===== rtl/twm_mix.sv =====
// Mix stage: sums voice samples, offsets, clamps and biases, holds result in the output register.
`timescale 1ns / 1ps
module twm_mix
	import twm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         tick_acc,
	input  voice_data_t  rd_data_s1,
	output pipe_stat_t   stat,
	twm_sample_if.source sample
);

	logic    valid_s1;
	logic    out_valid_q;
	sample_t sample_q;
	logic    s1_move;

	logic [SUM_W-1:0]        sum;
	logic signed [MIX_W-1:0] mix;
	logic signed [MIX_W-1:0] mix_clamped;
	logic signed [MIX_W-1:0] biased;
	sample_t                 sample_d;

	assign s1_move       = valid_s1 && (!out_valid_q || sample.ready);
	assign stat.s1_valid = valid_s1;
	assign stat.in_ready = !valid_s1 || s1_move;

	always_comb begin
		sum = SUM_W'(rd_data_s1[0]) + SUM_W'(rd_data_s1[1])
			+ SUM_W'(rd_data_s1[2][SAMPLE_W-1:1]);
		mix = $signed({1'b0, sum[SUM_W-1:1]}) - MIX_OFFSET;
		// mix never drops below -127, so only the top is clamped
		mix_clamped = (mix > MIX_MAX) ? MIX_MAX : mix;
		biased      = mix_clamped - OUT_BIAS;
		sample_d    = biased[SAMPLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tick_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (sample.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			sample_q <= sample_d;
		end
	end

	assign sample.valid      = out_valid_q;
	assign sample.sample_out = sample_q;

endmodule

// ===== sim/three_voice_wavetable_mixer_top_test.sv =====
// Self-checking testbench for the three-voice wavetable mixer top level.
`timescale 1ns / 1ps
module three_voice_wavetable_mixer_top_test;
	import twm_pkg::*;

	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 250;
	localparam int FINAL_ITEMS   = 300;

	logic clk = 1'b0;
	logic arst_n;

	twm_item_if   item_if ();
	twm_sample_if sample_if ();
	twm_cfg_if    cfg_if ();

	three_voice_wavetable_mixer_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.sample (sample_if),
		.cfg    (cfg_if)
	);

	// Shadow of the block state
	sample_t wave_mem [256]          = '{default: '0};
	phase_t  phase_acc [VOICE_COUNT] = '{default: '0};
	phase_t  phase_step [VOICE_COUNT] = '{default: '0};

	sample_t expected_samples [$];
	int      mismatches = 0;
	bit      gaps_on    = 1'b1;
	bit      stalls_on  = 1'b1;

	always #1 clk = ~clk;

	// Reads all voices at the current phases, then advances the phases.
	function automatic sample_t mix_voices();
		int total;
		int mix;
		total = int'(wave_mem[phase_acc[0][15:8]]) + int'(wave_mem[phase_acc[1][15:8]])
			+ (int'(wave_mem[phase_acc[2][15:8]]) >> 1);
		for (int v = 0; v < VOICE_COUNT; v++)
			phase_acc[v] = phase_acc[v] + phase_step[v];
		mix = total / 2 - 127;
		if (mix > 127)
			mix = 127;
		return sample_t'(mix + 128);
	endfunction

	function automatic phase_t pick_step();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return phase_t'($urandom_range(1, 16'h0400));
			default: return phase_t'($urandom_range(0, 16'hffff));
		endcase
	endfunction

	task automatic send_item(op_t op, tbl_idx_t idx, sample_t val);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			item_if.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		item_if.valid       <= 1'b1;
		item_if.op          <= op;
		item_if.table_index <= idx;
		item_if.table_value <= val;
		do @(posedge clk); while (!item_if.ready);
		if (op == OP_WRITE)
			wave_mem[idx] = val;
		else
			expected_samples.push_back(mix_voices());
		@(negedge clk);
	endtask

	task automatic send_random_item();
		op_t     op;
		sample_t val;
		if ($urandom_range(0, 9) < 4)
			op = OP_WRITE;
		else
			op = OP_TICK;
		// bias some writes high so the upper clamp gets hit
		val = ($urandom_range(0, 3) == 0) ? sample_t'($urandom_range(200, 255))
			: sample_t'($urandom_range(0, 255));
		send_item(op, tbl_idx_t'($urandom_range(0, 255)), val);
	endtask

	// Stop items and let the pipeline empty out.
	task automatic drain_samples();
		item_if.valid <= 1'b0;
		while (expected_samples.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, phase_t data);
		cfg_if.valid     <= 1'b1;
		cfg_if.reg_index <= idx;
		cfg_if.wr_data   <= data;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			REG_STEP_A: phase_step[0] = data;
			REG_STEP_B: phase_step[1] = data;
			REG_STEP_C: phase_step[2] = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_steps(phase_t a, phase_t b, phase_t c);
		write_reg(REG_STEP_A, a);
		write_reg(REG_STEP_B, b);
		write_reg(REG_STEP_C, c);
	endtask

	// Cleared table with zero steps: every tick sits at the bottom of the range.
	task automatic test_reset_state();
		send_item(OP_TICK, '0, '0);
		send_item(OP_TICK, '1, '1);
		send_item(OP_WRITE, 8'h80, 8'h00);
	endtask

	// Writes to the spare index must not touch any step register.
	task automatic test_unknown_register();
		send_item(OP_WRITE, 8'hff, 8'hff);
		drain_samples();
		write_reg(REG_UNMAPPED, 16'hffff);
		repeat (3) send_item(OP_TICK, '0, '0);
	endtask

	// All voices on entry 0; values around the point where the mix saturates.
	task automatic test_clamp();
		send_item(OP_WRITE, 8'h00, 8'hff);
		send_item(OP_TICK, '0, '0);
		send_item(OP_WRITE, 8'h00, 8'd204);
		send_item(OP_TICK, '0, '0);
		send_item(OP_WRITE, 8'h00, 8'd203);
		send_item(OP_TICK, '0, '0);
	endtask

	task automatic test_step_extremes();
		drain_samples();
		set_steps(16'hffff, 16'h0100, 16'h8000);
		send_item(OP_WRITE, 8'h80, 8'haa);
		send_item(OP_WRITE, 8'h01, 8'h55);
		repeat (5) send_item(OP_TICK, '0, '0);
	endtask

	task automatic test_random_traffic();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_samples();
			set_steps(pick_step(), pick_step(), pick_step());
			if (p == 3)
				write_reg(REG_UNMAPPED, phase_t'($urandom_range(0, 16'hffff)));
			gaps_on   = (p != 2);
			stalls_on = (p != 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1 && n == PHASE_ITEMS / 2)
					drain_samples();
				send_random_item();
			end
		end
	endtask

	task automatic test_full_rate();
		drain_samples();
		set_steps(pick_step(), pick_step(), pick_step());
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		repeat (FINAL_ITEMS) send_random_item();
	endtask

	// Sample sink back-pressure
	initial begin
		sample_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stalls_on && $urandom_range(0, 7) == 0) begin
				sample_if.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			sample_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_samples
		sample_t want;
		if (arst_n && sample_if.valid && sample_if.ready) begin
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected sample_out %02h, none pending", $time,
					sample_if.sample_out);
				mismatches++;
			end else begin
				want = expected_samples.pop_front();
				if (sample_if.sample_out !== want) begin
					$display("%0t: sample_out expected %02h, actual %02h", $time, want,
						sample_if.sample_out);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int waited;
		arst_n              = 1'b0;
		item_if.valid       = 1'b0;
		item_if.op          = OP_WRITE;
		item_if.table_index = '0;
		item_if.table_value = '0;
		cfg_if.valid        = 1'b0;
		cfg_if.reg_index    = REG_STEP_A;
		cfg_if.wr_data      = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_unknown_register();
		test_clamp();
		test_step_extremes();
		test_random_traffic();
		test_full_rate();

		item_if.valid <= 1'b0;
		waited = 0;
		while (expected_samples.size() != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_samples.size() != 0) begin
			$display("%0t: %0d expected samples never arrived", $time,
				expected_samples.size());
			mismatches += expected_samples.size();
		end
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog
	initial begin
		#1_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== three_voice_wavetable_mixer_top.f =====
rtl/twm_pkg.sv
rtl/twm_item_if.sv
rtl/twm_sample_if.sv
rtl/twm_cfg_if.sv
rtl/twm_wave_mem.sv
rtl/twm_voice_core.sv
rtl/twm_mix.sv
rtl/three_voice_wavetable_mixer_top.sv
sim/three_voice_wavetable_mixer_top_test.sv
